>>> hw/rtl/svie_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svie_pkg
// Shared constants, codes and control structs of the stack machine executor.
// ----------------------------------------------------------------------------
package svie_pkg;

    localparam int DATA_W           = 32;
    localparam int ADDR_W           = 16;
    localparam int DATA_STACK_DEPTH = 1024;
    localparam int DS_AW            = $clog2(DATA_STACK_DEPTH);
    localparam int DEPTH_W          = $clog2(DATA_STACK_DEPTH + 1);
    localparam int CALL_DEPTH       = 16;
    localparam int RS_AW            = $clog2(CALL_DEPTH);
    localparam int LEVEL_W          = $clog2(CALL_DEPTH + 1);
    localparam int LEVELS           = CALL_DEPTH + 1;
    localparam int SLOT_W           = 8;
    localparam int LOCAL_SLOTS      = 256;
    localparam int LOCAL_ENTRIES    = LEVELS * LOCAL_SLOTS;
    localparam int LOCAL_AW         = $clog2(LOCAL_ENTRIES);
    localparam int GLOBAL_SLOTS     = 256;
    localparam int EPOCH_W          = 8;

    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_BRT   = 4'd1,
        OP_BRF   = 4'd2,
        OP_JMP   = 4'd3,
        OP_CALL  = 4'd4,
        OP_RET   = 4'd5,
        OP_LDLOC = 4'd6,
        OP_LDGLB = 4'd7,
        OP_STLOC = 4'd8,
        OP_STGLB = 4'd9,
        OP_PUSH  = 4'd10,
        OP_DBG   = 4'd11
    } opcode_t;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_END     = 3'd1,
        ST_UNDER   = 3'd2,
        ST_OVER    = 3'd3,
        ST_CALLOVF = 3'd4,
        ST_UNKNOWN = 3'd5
    } status_t;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_EXEC  = 1'b1
    } action_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic                rd_en;
        logic [LEVEL_W-1:0]  rd_level;
        logic [SLOT_W-1:0]   rd_slot;
        logic                loc_we;
        logic                glb_we;
        logic [LEVEL_W-1:0]  wr_level;
        logic [SLOT_W-1:0]   wr_slot;
        logic [DATA_W-1:0]   wr_data;
        logic                frame_new;
        logic [LEVEL_W-1:0]  frame_level;
    } vars_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] loc_data;
        logic [DATA_W-1:0] glb_data;
        logic              busy;
    } vars_rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/svie_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svie_in_if
// Request channel: one instruction or run start per request.
// ----------------------------------------------------------------------------
interface svie_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  opcode;
    logic [15:0] immediate;

    modport source (output valid, action, opcode, immediate, input ready);
    modport sink   (input valid, action, opcode, immediate, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/svie_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svie_out_if
// Result channel: machine state after each request.
// ----------------------------------------------------------------------------
interface svie_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        next_address;
    logic               halted;
    logic [2:0]         status;
    logic signed [31:0] stack_top;
    logic [10:0]        stack_depth;

    modport source (output valid, next_address, halted, status, stack_top, stack_depth,
                    input ready);
    modport sink   (input valid, next_address, halted, status, stack_top, stack_depth,
                    output ready);
endinterface
`default_nettype wire

>>> hw/rtl/stack_vm_instruction_execute.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stack_vm_instruction_execute
// Executes one stack machine instruction or run start per request.
// ----------------------------------------------------------------------------
// The accept cycle issues reads of the data stack, local frame and global
// memories. The next cycle updates state, writes back and loads the result
// register. No new request is taken while one executes, and a result that
// waits holds off the next request until it is taken. The top of stack
// lives in a register; a pop refills it from the stack memory read. After
// reset the block sweeps the local memory, one entry a cycle, over all 4352
// entries before it takes a request; every 256th new frame at one call level
// causes a sweep of the 256 entries of that level.
// ----------------------------------------------------------------------------
module stack_vm_instruction_execute (
    input  wire logic   clk,
    input  wire logic   rst_n,
    svie_in_if.sink     cmd,
    svie_out_if.source  rsp
);

    svie_pkg::state_t                   state_reg, state_next;
    logic [svie_pkg::ADDR_W-1:0]        pc_reg, pc_next;
    logic                               running_reg, running_next;
    svie_pkg::status_t                  last_reg, last_next;
    logic [svie_pkg::DEPTH_W-1:0]       depth_reg, depth_next;
    logic [svie_pkg::DATA_W-1:0]        top_reg, top_next;
    logic [svie_pkg::LEVEL_W-1:0]       level_reg, level_next;
    logic [svie_pkg::ADDR_W-1:0]        ret_stack [svie_pkg::CALL_DEPTH];

    logic                               act_reg;
    logic [3:0]                         op_reg;
    logic [15:0]                        imm_reg;

    logic                               out_valid_reg;
    logic [svie_pkg::ADDR_W-1:0]        out_addr_reg;
    logic                               out_halt_reg;
    logic [2:0]                         out_status_reg;
    logic [svie_pkg::DATA_W-1:0]        out_top_reg;
    logic [svie_pkg::DEPTH_W-1:0]       out_depth_reg;

    logic                               accept;
    logic                               exec;
    logic [svie_pkg::DATA_W-1:0]        ds_rd_data;
    logic                               ds_we;
    logic [svie_pkg::DS_AW-1:0]         ds_waddr;
    logic [svie_pkg::DATA_W-1:0]        ds_wdata;
    logic                               rs_we;
    logic [svie_pkg::ADDR_W-1:0]        rs_wdata;
    logic [svie_pkg::DEPTH_W-1:0]       depth_m2;
    svie_pkg::vars_req_t                vreq;
    svie_pkg::vars_rsp_t                vrsp;

    assign cmd.ready = (state_reg == svie_pkg::S_IDLE) && !vrsp.busy
                       && (!out_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;
    assign exec      = (state_reg == svie_pkg::S_EXEC);
    assign depth_m2  = depth_reg - svie_pkg::DEPTH_W'(2);

    svie_dstack u_dstack (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (depth_m2[svie_pkg::DS_AW-1:0]),
        .rd_data (ds_rd_data),
        .wr_en   (ds_we),
        .wr_addr (ds_waddr),
        .wr_data (ds_wdata)
    );

    svie_vars u_vars (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (vreq),
        .rsp   (vrsp)
    );

    always_comb
    begin
        logic [svie_pkg::ADDR_W-1:0] nxt;
        logic [svie_pkg::ADDR_W-1:0] off;
        logic [svie_pkg::DATA_W-1:0] val;
        logic                        pop_ok;
        logic                        push_ok;
        logic                        cond;
        svie_pkg::status_t           st;

        off     = svie_pkg::ADDR_W'(imm_reg);
        nxt     = pc_reg + 1'b1;
        val     = '0;
        pop_ok  = (depth_reg != '0);
        push_ok = (depth_reg < svie_pkg::DEPTH_W'(svie_pkg::DATA_STACK_DEPTH));
        cond    = pop_ok && (top_reg != '0);
        st      = svie_pkg::ST_RUN;

        state_next   = state_reg;
        pc_next      = pc_reg;
        running_next = running_reg;
        last_next    = last_reg;
        depth_next   = depth_reg;
        top_next     = top_reg;
        level_next   = level_reg;
        ds_we        = 1'b0;
        ds_waddr     = depth_reg[svie_pkg::DS_AW-1:0];
        ds_wdata     = '0;
        rs_we        = 1'b0;
        rs_wdata     = pc_reg + svie_pkg::ADDR_W'(2);

        vreq.rd_en       = accept;
        vreq.rd_level    = level_reg;
        vreq.rd_slot     = cmd.immediate[svie_pkg::SLOT_W-1:0];
        vreq.loc_we      = 1'b0;
        vreq.glb_we      = 1'b0;
        vreq.wr_level    = level_reg;
        vreq.wr_slot     = imm_reg[svie_pkg::SLOT_W-1:0];
        vreq.wr_data     = top_reg;
        vreq.frame_new   = 1'b0;
        vreq.frame_level = level_reg + 1'b1;

        unique case (state_reg)
            svie_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = svie_pkg::S_EXEC;
                end
            end
            svie_pkg::S_EXEC:
            begin
                state_next = svie_pkg::S_IDLE;
                if (act_reg == svie_pkg::ACT_START)
                begin
                    pc_next          = svie_pkg::ADDR_W'(imm_reg);
                    running_next     = 1'b1;
                    level_next       = '0;
                    last_next        = svie_pkg::ST_RUN;
                    vreq.frame_new   = 1'b1;
                    vreq.frame_level = '0;
                end
                else if (running_reg)
                begin
                    unique case (op_reg)
                        svie_pkg::OP_BRT, svie_pkg::OP_BRF:
                        begin
                            if (!pop_ok)
                            begin
                                st = svie_pkg::ST_UNDER;
                            end
                            else
                            begin
                                depth_next = depth_reg - 1'b1;
                                top_next   = ds_rd_data;
                            end
                            if ((op_reg == svie_pkg::OP_BRT) == cond)
                            begin
                                nxt = pc_reg + off;
                            end
                        end
                        svie_pkg::OP_JMP:
                        begin
                            nxt = pc_reg + off;
                        end
                        svie_pkg::OP_CALL:
                        begin
                            if (level_reg >= svie_pkg::LEVEL_W'(svie_pkg::CALL_DEPTH))
                            begin
                                st = svie_pkg::ST_CALLOVF;
                            end
                            else
                            begin
                                rs_we          = 1'b1;
                                level_next     = level_reg + 1'b1;
                                vreq.frame_new = 1'b1;
                            end
                            nxt = pc_reg + off;
                        end
                        svie_pkg::OP_RET:
                        begin
                            if (level_reg == '0)
                            begin
                                st = svie_pkg::ST_END;
                            end
                            else
                            begin
                                level_next = level_reg - 1'b1;
                                nxt = ret_stack[level_next[svie_pkg::RS_AW-1:0]] + 1'b1;
                            end
                        end
                        svie_pkg::OP_LDLOC, svie_pkg::OP_LDGLB,
                        svie_pkg::OP_PUSH:
                        begin
                            nxt = pc_reg + svie_pkg::ADDR_W'(2);
                            priority if (op_reg == svie_pkg::OP_LDLOC)
                            begin
                                val = vrsp.loc_data;
                            end
                            else if (op_reg == svie_pkg::OP_LDGLB)
                            begin
                                val = vrsp.glb_data;
                            end
                            else
                            begin
                                val = svie_pkg::DATA_W'(imm_reg[svie_pkg::SLOT_W-1:0]);
                            end
                            if (push_ok)
                            begin
                                ds_we      = 1'b1;
                                ds_wdata   = val;
                                depth_next = depth_reg + 1'b1;
                                top_next   = val;
                            end
                            else if (op_reg != svie_pkg::OP_PUSH)
                            begin
                                st = svie_pkg::ST_OVER;
                            end
                        end
                        svie_pkg::OP_STLOC, svie_pkg::OP_STGLB:
                        begin
                            nxt = pc_reg + svie_pkg::ADDR_W'(2);
                            if (!pop_ok)
                            begin
                                st = svie_pkg::ST_UNDER;
                            end
                            else
                            begin
                                depth_next  = depth_reg - 1'b1;
                                top_next    = ds_rd_data;
                                vreq.loc_we = (op_reg == svie_pkg::OP_STLOC);
                                vreq.glb_we = (op_reg == svie_pkg::OP_STGLB);
                            end
                        end
                        svie_pkg::OP_NOP, svie_pkg::OP_DBG:
                        begin
                        end
                        default:
                        begin
                            st = svie_pkg::ST_UNKNOWN;
                        end
                    endcase
                    pc_next   = nxt;
                    last_next = st;
                    if (st != svie_pkg::ST_RUN)
                    begin
                        running_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = svie_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svie_pkg::S_IDLE;
            pc_reg        <= '0;
            running_reg   <= 1'b0;
            last_reg      <= svie_pkg::ST_RUN;
            depth_reg     <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            running_reg <= running_next;
            last_reg    <= last_next;
            depth_reg   <= depth_next;
            level_reg   <= level_next;
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (accept)
        begin
            act_reg <= cmd.action;
            op_reg  <= cmd.opcode;
            imm_reg <= cmd.immediate;
        end
        if (rs_we)
        begin
            ret_stack[level_reg[svie_pkg::RS_AW-1:0]] <= rs_wdata;
        end
        if (exec)
        begin
            out_addr_reg   <= pc_next;
            out_halt_reg   <= !running_next;
            out_status_reg <= running_next ? svie_pkg::ST_RUN : last_next;
            out_top_reg    <= (depth_next == '0) ? '0 : top_next;
            out_depth_reg  <= depth_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.next_address = out_addr_reg;
    assign rsp.halted       = out_halt_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.stack_top    = out_top_reg;
    assign rsp.stack_depth  = out_depth_reg;

endmodule
`default_nettype wire

>>> hw/rtl/svie_dstack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svie_dstack
// Data stack memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module svie_dstack (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [svie_pkg::DS_AW-1:0]   rd_addr,
    output logic      [svie_pkg::DATA_W-1:0]  rd_data,
    input  wire logic                         wr_en,
    input  wire logic [svie_pkg::DS_AW-1:0]   wr_addr,
    input  wire logic [svie_pkg::DATA_W-1:0]  wr_data
);

    logic [svie_pkg::DATA_W-1:0] mem [svie_pkg::DATA_STACK_DEPTH];
    logic [svie_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/svie_vars.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svie_vars
// Local frames and globals. Locals carry an epoch tag per entry; a new frame
// bumps its level's epoch, and a wrap of the epoch sweeps that level clean.
// Reset sweeps the whole local memory. Globals use one valid bit per slot.
// ----------------------------------------------------------------------------
module svie_vars (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire svie_pkg::vars_req_t  req,
    output svie_pkg::vars_rsp_t       rsp
);

    localparam int LW = svie_pkg::EPOCH_W + svie_pkg::DATA_W;

    logic [LW-1:0]                      loc_mem [svie_pkg::LOCAL_ENTRIES];
    logic [svie_pkg::DATA_W-1:0]        glb_mem [svie_pkg::GLOBAL_SLOTS];
    logic [svie_pkg::GLOBAL_SLOTS-1:0]  glb_valid_reg;
    logic [svie_pkg::EPOCH_W-1:0]       epoch_reg [svie_pkg::LEVELS];

    logic [LW-1:0]                      loc_rd_reg;
    logic [svie_pkg::DATA_W-1:0]        glb_rd_reg;
    logic                               glb_ok_reg;
    logic [svie_pkg::LEVEL_W-1:0]       rd_level_reg;

    logic                               clearing_reg;
    logic [svie_pkg::LOCAL_AW-1:0]      clr_ptr_reg;
    logic [svie_pkg::LOCAL_AW-1:0]      clr_end_reg;

    logic [svie_pkg::LOCAL_AW-1:0]      rd_addr;
    logic [svie_pkg::LOCAL_AW-1:0]      wr_addr;
    logic [svie_pkg::LOCAL_AW-1:0]      frame_base;
    logic                               epoch_wrap;

    assign rd_addr    = svie_pkg::LOCAL_AW'({req.rd_level, req.rd_slot});
    assign wr_addr    = svie_pkg::LOCAL_AW'({req.wr_level, req.wr_slot});
    assign frame_base = svie_pkg::LOCAL_AW'({req.frame_level, {svie_pkg::SLOT_W{1'b0}}});
    assign epoch_wrap = req.frame_new && (epoch_reg[req.frame_level] == {svie_pkg::EPOCH_W{1'b1}});

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            loc_mem[clr_ptr_reg] <= '0;
        end
        else if (req.loc_we)
        begin
            loc_mem[wr_addr] <= {epoch_reg[req.wr_level], req.wr_data};
        end
        if (req.glb_we)
        begin
            glb_mem[req.wr_slot] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            loc_rd_reg   <= loc_mem[rd_addr];
            glb_rd_reg   <= glb_mem[req.rd_slot];
            glb_ok_reg   <= glb_valid_reg[req.rd_slot];
            rd_level_reg <= req.rd_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glb_valid_reg <= '0;
            clearing_reg  <= 1'b1;
            clr_ptr_reg   <= '0;
            clr_end_reg   <= svie_pkg::LOCAL_AW'(svie_pkg::LOCAL_ENTRIES - 1);
            for (int i = 0; i < svie_pkg::LEVELS; i++)
            begin
                epoch_reg[i] <= '0;
            end
        end
        else
        begin
            if (req.glb_we)
            begin
                glb_valid_reg[req.wr_slot] <= 1'b1;
            end
            if (req.frame_new)
            begin
                epoch_reg[req.frame_level] <= epoch_reg[req.frame_level] + 1'b1;
            end
            if (epoch_wrap)
            begin
                clearing_reg <= 1'b1;
                clr_ptr_reg  <= frame_base;
                clr_end_reg  <= frame_base + svie_pkg::LOCAL_AW'(svie_pkg::LOCAL_SLOTS - 1);
            end
            else if (clearing_reg)
            begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == clr_end_reg)
                begin
                    clearing_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        rsp.busy     = clearing_reg;
        rsp.glb_data = glb_ok_reg ? glb_rd_reg : '0;
        rsp.loc_data = (loc_rd_reg[LW-1:svie_pkg::DATA_W] == epoch_reg[rd_level_reg])
                       ? loc_rd_reg[svie_pkg::DATA_W-1:0] : '0;
    end

endmodule
`default_nettype wire
